[src/dqsd_pkg.sv]
`timescale 1ns / 1ps
package dqsd_pkg;

   // Action codes carried in the request
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_REMOVE     = 3'd4;
   localparam logic [2:0] ACT_SEARCH     = 3'd5;

   // Status codes returned in the response
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   // Per-cell update commands
   localparam logic [2:0] CELL_HOLD       = 3'd0;
   localparam logic [2:0] CELL_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CELL_PUSH_BACK  = 3'd2;
   localparam logic [2:0] CELL_POP_FRONT  = 3'd3;
   localparam logic [2:0] CELL_POP_BACK   = 3'd4;
   localparam logic [2:0] CELL_REMOVE     = 3'd5;

   localparam int VALUE_W = 32;

   // Command broadcast to every cell
   typedef struct packed {
      logic [2:0]         op;
      logic [VALUE_W-1:0] key;
   } cell_ctrl_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic               occ;
      logic [VALUE_W-1:0] data;
   } link_type;

endpackage

[src/deque_with_search_and_delete.sv]
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit values with search and delete.
// Request channel (req_*): one action per transfer: push front, push back,
// pop front, pop back, remove first match, search. Codes six and seven are
// accepted and change nothing.
// Response channel (rsp_*): exactly one transfer per request, carrying a
// status, a found flag and the entry count after the action.
// Storage is a row of DEPTH cells, front at cell 0. Every cell compares its
// entry against the key in parallel and takes its next value from itself,
// a neighbor or the request key, so any action completes in the cycle it
// is accepted. The response is valid the cycle after the request transfer.
// Throughput: one request per cycle while the response side keeps up; the
// response register frees up in the same cycle it is taken.
// Reset clears all cell occupancy flags and the count; entry data is not
// reset. When rsp_tready is low the response holds and req_tready drops
// until the pending response is taken.
module deque_with_search_and_delete #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] action, [34:3] value, [39:35] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] status, [2] found, [7:3] count
);
   import dqsd_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic                req_fire;
   logic [2:0]          req_action;
   logic [VALUE_W-1:0]  req_value;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_tvalid_ff;
   logic [7:0]          rsp_tdata_ff;
   logic [1:0]          status;
   logic                found;
   logic                full;
   logic                empty;
   logic                any_match;
   cell_ctrl_type       ctrl;
   link_type            links [DEPTH];
   logic [DEPTH:0]      seen;
   logic [DEPTH-1:0]    occ_vec;

   assign req_action = req_tdata[2:0];
   assign req_value  = req_tdata[34:3];
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign full      = links[DEPTH-1].occ;
   assign empty     = !links[0].occ;
   assign any_match = seen[DEPTH];

   // Row of storage cells with the first-match chain running front to back
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type left_link;
      link_type right_link;
      if (i == 0) begin : g_head
         assign left_link = '{occ: 1'b1, data: ctrl.key};
      end else begin : g_left
         assign left_link = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_link = '{occ: 1'b0, data: '0};
      end else begin : g_right
         assign right_link = links[i+1];
      end
      dqsd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (left_link),
         .right_link (right_link),
         .seen_in    (seen[i]),
         .seen_out   (seen[i+1]),
         .link_out   (links[i])
      );
      assign occ_vec[i] = links[i].occ;
   end

   // Decode the action into a cell command, status and new count
   always_comb begin
      ctrl.op  = CELL_HOLD;
      ctrl.key = req_value;
      status   = ST_DONE;
      found    = 1'b0;
      count_in = count_ff;
      case (req_action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.op  = (req_action == ACT_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                         : CELL_PUSH_BACK;
               count_in = count_ff + CW'(1);
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               ctrl.op  = (req_action == ACT_POP_FRONT) ? CELL_POP_FRONT
                                                        : CELL_POP_BACK;
               count_in = count_ff - CW'(1);
            end
         end
         ACT_REMOVE, ACT_SEARCH: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (!any_match) begin
               status = ST_MISSING;
            end else begin
               found = 1'b1;
               if (req_action == ACT_REMOVE) begin
                  ctrl.op  = CELL_REMOVE;
                  count_in = count_ff - CW'(1);
               end
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
      // Only a transfer changes the store
      if (!req_fire) begin
         ctrl.op  = CELL_HOLD;
         count_in = count_ff;
      end
   end

   // Track the entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Load the response register on a request, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_tdata_ff <= {5'(count_in), found, status};
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == int'(count_ff))
      else $error("cell occupancy disagrees with count");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid_ff)
      else $error("no response after request transfer");

   a_push_front_lands: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action == ACT_PUSH_FRONT && !full)
      |=> (links[0].occ && links[0].data == $past(req_value)))
      else $error("push front did not land in the head cell");
`endif

endmodule

[src/dqsd_cell.sv]
`timescale 1ns / 1ps
module dqsd_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  dqsd_pkg::cell_ctrl_type ctrl,
   input  dqsd_pkg::link_type      left_link,
   input  dqsd_pkg::link_type      right_link,
   input  logic                    seen_in,
   output logic                    seen_out,
   output dqsd_pkg::link_type      link_out
);
   import dqsd_pkg::*;

   logic               occ_ff;
   logic               occ_in;
   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               match;

   // Compare the held entry and extend the first-match chain
   assign match    = occ_ff && (data_ff == ctrl.key);
   assign seen_out = seen_in | match;
   assign link_out = '{occ: occ_ff, data: data_ff};

   // Pick the next contents from self, a neighbor or the command key
   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      case (ctrl.op)
         CELL_PUSH_FRONT: begin
            occ_in  = left_link.occ;
            data_in = left_link.data;
         end
         CELL_PUSH_BACK: begin
            if (!occ_ff && left_link.occ) begin
               occ_in  = 1'b1;
               data_in = ctrl.key;
            end
         end
         CELL_POP_FRONT: begin
            occ_in  = right_link.occ;
            data_in = right_link.data;
         end
         CELL_POP_BACK: begin
            if (occ_ff && !right_link.occ) begin
               occ_in = 1'b0;
            end
         end
         CELL_REMOVE: begin
            // Cells at or behind the first match close the gap
            if (seen_out) begin
               occ_in  = right_link.occ;
               data_in = right_link.data;
            end
         end
         default: begin
            occ_in  = occ_ff;
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
